// File: src/cbpg_pkg.sv
// shared constants, types and state encoding for the cubic bezier point generator
package cbpg_pkg;

  // sizing
  localparam int MAX_POINTS  = 64;
  localparam int T_FRAC_BITS = 16;
  localparam int COORD_W     = 32;
  localparam int COUNT_W     = 7;
  localparam int T_W         = T_FRAC_BITS + 1;
  localparam int N_W         = $clog2(MAX_POINTS + 1);
  localparam int D_W         = $clog2(MAX_POINTS);
  localparam int STEP_W      = $clog2(T_FRAC_BITS + 1);
  localparam int REG_IDX_W   = 3;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 2 * COORD_W;

  // weight arithmetic
  localparam int SQ_W      = 2 * T_FRAC_BITS + 1;
  localparam int M3_W      = T_FRAC_BITS + 2;
  localparam int WMUL_W    = SQ_W + M3_W;
  localparam int W_W       = 3 * T_FRAC_BITS + 1;
  localparam int WLO_W     = (W_W + 1) / 2;
  localparam int PROD_W    = COORD_W + WLO_W + 1;
  localparam int SUM_SHIFT = 3 * T_FRAC_BITS;
  localparam int ACC_W     = SUM_SHIFT + COORD_W + 2;
  localparam int Q_W       = ACC_W - SUM_SHIFT;

  // four terms, each split in two halves of the weight
  localparam int TERM_STEPS = 8;

  localparam logic [T_W-1:0] ONE_T = T_W'(1) << T_FRAC_BITS;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_P0_X, REG_P0_Y, REG_P1_X, REG_P1_Y,
    REG_P2_X, REG_P2_Y, REG_P3_X, REG_P3_Y
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_WSQ, ST_WCUBE, ST_WMIX, ST_TERM, ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    T_KEEP, T_INPUT, T_ZERO
  } t_src_t;

  typedef enum logic [1:0] {
    WOP_NONE, WOP_SQ, WOP_CUBE, WOP_MIX
  } wop_t;

  typedef struct packed {
    t_src_t         t_src;
    logic           div_load;
    logic [D_W-1:0] divisor;
    logic           div_step;
    logic           div_bit;
    wop_t           wop;
    logic           acc_clear;
    logic           mul;
    logic [1:0]     term;
    logic           half;
    logic           out_load;
    logic           out_last;
    logic           t_adv;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// File: src/cubic_bezier_point_generator_core.sv
// top level of the cubic bezier point generator
// a single point runs the weight square, cube and mix steps, the term products and the
//   finish; an evenly spaced run first runs the step divider (one quotient bit a cycle)
// per point: the weight multipliers, then the eight half-weight products through the
//   shared x/y term multipliers; the finish step waits while the output register is full
// a new request is taken once the last point of the previous one is in the output register
// reset is synchronous and active high; it clears control and the control points to zero
module cubic_bezier_point_generator_core import cbpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // t_value, point_count
  input  logic                  s_tuser,   // func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // point_x, point_y
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  cbpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_func   (s_tuser),
    .s_count  (s_tdata[T_W +: COUNT_W]),
    .stat     (stat),
    .cmd      (cmd)
  );

  cbpg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .t_value   (s_tdata[T_W-1:0]),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// File: src/cbpg_ctrl.sv
// sequencer for the divider, weight and term steps of each curve point
module cbpg_ctrl import cbpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               s_func,
  input  logic [COUNT_W-1:0] s_count,
  input  dp_stat_t           stat,
  output dp_cmd_t            cmd
);

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] cnt;
  logic [N_W-1:0]    left;
  logic [COUNT_W-1:0] count_clamp;
  logic [N_W-1:0]    n_in;
  logic              accept;

  // clamp the requested number of points
  assign count_clamp = (s_count > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : s_count;
  assign n_in        = N_W'(count_clamp);
  assign s_tready    = (state == ST_IDLE);
  assign accept      = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!s_func) begin
            state_next = ST_WSQ;
          end else if (n_in == '0) begin
            state_next = ST_IDLE;
          end else if (n_in == N_W'(1)) begin
            state_next = ST_WSQ;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (cnt == STEP_W'(T_FRAC_BITS)) state_next = ST_WSQ;
      end
      ST_WSQ:   state_next = ST_WCUBE;
      ST_WCUBE: state_next = ST_WMIX;
      ST_WMIX:  state_next = ST_TERM;
      ST_TERM: begin
        if (cnt == STEP_W'(TERM_STEPS)) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) state_next = (left == N_W'(1)) ? ST_IDLE : ST_WSQ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!s_func) begin
            cmd.t_src = T_INPUT;
          end else if (n_in != '0) begin
            cmd.t_src = T_ZERO;
            if (n_in != N_W'(1)) begin
              cmd.div_load = 1'b1;
              cmd.divisor  = D_W'(n_in - N_W'(1));
            end
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_bit  = (cnt == '0);
      end
      ST_WSQ:   cmd.wop = WOP_SQ;
      ST_WCUBE: cmd.wop = WOP_CUBE;
      ST_WMIX: begin
        cmd.wop       = WOP_MIX;
        cmd.acc_clear = 1'b1;
      end
      ST_TERM: begin
        cmd.mul  = (cnt < STEP_W'(TERM_STEPS));
        cmd.term = cnt[2:1];
        cmd.half = cnt[0];
      end
      ST_FIN: begin
        cmd.out_load = stat.out_free;
        cmd.out_last = (left == N_W'(1));
        cmd.t_adv    = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

  // state, step counter and points still to emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      left  <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next == state) ? cnt + STEP_W'(1) : '0;
      if (accept) begin
        left <= s_func ? n_in : N_W'(1);
      end else if (state == ST_FIN && stat.out_free) begin
        left <= left - N_W'(1);
      end
    end
  end

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cnt <= STEP_W'(T_FRAC_BITS))
    else $error("divider ran past its last step");

  a_fin_left: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |-> left != '0)
    else $error("point emitted with none left");

  a_term_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && $past(state) == ST_TERM) |-> $past(cnt) == STEP_W'(TERM_STEPS))
    else $error("finish entered before all terms were accumulated");

endmodule

// File: src/cbpg_dp.sv
// control point registers, step divider, weight and term multipliers, accumulators
module cbpg_dp import cbpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data,
  input  logic [T_W-1:0]        t_value,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  logic signed [COORD_W-1:0] cx [4];
  logic signed [COORD_W-1:0] cy [4];

  logic [T_W-1:0]   t;
  logic [T_W-1:0]   u;
  logic [D_W-1:0]   dv;
  logic [D_W-1:0]   drem;
  logic [T_W-1:0]   dquo;
  logic [D_W-1:0]   r;
  logic [D_W:0]     dshift;
  logic             dge;
  logic [D_W:0]     rsum;
  logic             rge;

  logic [SQ_W-1:0]   uu;
  logic [SQ_W-1:0]   tt;
  logic [M3_W-1:0]   t3;
  logic [M3_W-1:0]   u3;
  logic [W_W-1:0]    w [4];
  logic [SQ_W-1:0]   ma0;
  logic [SQ_W-1:0]   ma1;
  logic [M3_W-1:0]   mb0;
  logic [M3_W-1:0]   mb1;
  logic [WMUL_W-1:0] mp0;
  logic [WMUL_W-1:0] mp1;

  logic [W_W-1:0]          wsel;
  logic signed [WLO_W:0]   wpart;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic                    pv;
  logic                    ph;
  logic [ACC_W-1:0]        ext_x;
  logic [ACC_W-1:0]        ext_y;
  logic [ACC_W-1:0]        acc_x;
  logic [ACC_W-1:0]        acc_y;

  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;

  // round half up, drop the fraction of the weights, saturate
  function automatic logic [COORD_W-1:0] finish_sum(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0]      rnd;
    logic [Q_W-1:0]        q;
    logic [Q_W-COORD_W:0]  top;
    rnd = acc + (ACC_W'(1) << (SUM_SHIFT - 1));
    q   = rnd[ACC_W-1:SUM_SHIFT];
    top = q[Q_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      finish_sum = q[COORD_W-1:0];
    end else if (q[Q_W-1]) begin
      finish_sum = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      finish_sum = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  // control point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        cx[k] <= '0;
        cy[k] <= '0;
      end
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_P0_X: cx[0] <= cfg_data;
        REG_P0_Y: cy[0] <= cfg_data;
        REG_P1_X: cx[1] <= cfg_data;
        REG_P1_Y: cy[1] <= cfg_data;
        REG_P2_X: cx[2] <= cfg_data;
        REG_P2_Y: cy[2] <= cfg_data;
        REG_P3_X: cx[3] <= cfg_data;
        REG_P3_Y: cy[3] <= cfg_data;
      endcase
    end
  end

  // restoring divide of one by the number of intervals (point count minus one), one quotient bit a step
  assign dshift = {drem, cmd.div_bit};
  assign dge    = (dshift >= {1'b0, dv});

  // step t by quotient, carry the remainder
  assign rsum = {1'b0, r} + {1'b0, drem};
  assign rge  = (rsum >= {1'b0, dv});
  assign u    = ONE_T - t;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dv   <= cmd.divisor;
      drem <= '0;
      dquo <= '0;
    end else if (cmd.div_step) begin
      drem <= dge ? D_W'(dshift - {1'b0, dv}) : D_W'(dshift);
      dquo <= {dquo[T_W-2:0], dge};
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.t_src)
      T_INPUT: t <= (t_value > ONE_T) ? ONE_T : t_value;
      T_ZERO: begin
        t <= '0;
        r <= '0;
      end
      T_KEEP: begin
        if (cmd.t_adv) begin
          r <= rge ? D_W'(rsum - {1'b0, dv}) : D_W'(rsum);
          t <= t + dquo + T_W'(rge);
        end
      end
      default: t <= t;
    endcase
  end

  // weight multiplier operand selection
  always_comb begin
    unique case (cmd.wop)
      WOP_SQ: begin
        ma0 = SQ_W'(u);
        mb0 = M3_W'(u);
        ma1 = SQ_W'(t);
        mb1 = M3_W'(t);
      end
      WOP_CUBE: begin
        ma0 = uu;
        mb0 = M3_W'(u);
        ma1 = tt;
        mb1 = M3_W'(t);
      end
      WOP_MIX: begin
        ma0 = uu;
        mb0 = t3;
        ma1 = tt;
        mb1 = u3;
      end
      WOP_NONE: begin
        ma0 = '0;
        mb0 = '0;
        ma1 = '0;
        mb1 = '0;
      end
    endcase
  end

  assign mp0 = ma0 * mb0;
  assign mp1 = ma1 * mb1;

  // bernstein weights
  always_ff @(posedge clk) begin
    unique case (cmd.wop)
      WOP_SQ: begin
        uu <= SQ_W'(mp0);
        tt <= SQ_W'(mp1);
        t3 <= M3_W'(t) + (M3_W'(t) << 1);
        u3 <= M3_W'(u) + (M3_W'(u) << 1);
      end
      WOP_CUBE: begin
        w[0] <= W_W'(mp0);
        w[3] <= W_W'(mp1);
      end
      WOP_MIX: begin
        w[1] <= W_W'(mp0);
        w[2] <= W_W'(mp1);
      end
      WOP_NONE: begin
        uu <= uu;
      end
    endcase
  end

  // term products: coordinate times one half of a weight
  assign wsel  = w[cmd.term];
  assign wpart = cmd.half ? {1'b0, WLO_W'(wsel[W_W-1:WLO_W])} : {1'b0, wsel[WLO_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_x <= cx[cmd.term] * wpart;
      prod_y <= cy[cmd.term] * wpart;
    end
    ph <= cmd.half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= cmd.mul;
    end
  end

  // accumulate, high halves weighted up by the low half width
  assign ext_x = {{(ACC_W-PROD_W){prod_x[PROD_W-1]}}, prod_x};
  assign ext_y = {{(ACC_W-PROD_W){prod_y[PROD_W-1]}}, prod_y};

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc_x <= '0;
      acc_y <= '0;
    end else if (pv) begin
      acc_x <= acc_x + (ph ? (ext_x << WLO_W) : ext_x);
      acc_y <= acc_y + (ph ? (ext_y << WLO_W) : ext_y);
    end
  end

  // output register
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x   <= finish_sum(acc_x);
      out_y   <= finish_sum(acc_y);
      m_tlast <= cmd.out_last;
    end
  end

  assign m_tdata = {out_y, out_x};

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result overwritten before it was taken");

endmodule

// File: verif/cbpg_tb_pkg.sv
// request kind codes shared by the cubic bezier testbench modules
package cbpg_tb_pkg;

  // tuser of a request
  localparam logic FUNC_AT_T   = 1'b0;
  localparam logic FUNC_SPREAD = 1'b1;

endpackage

// File: verif/cbpg_point_checker.sv
// point checker: tracks control points, predicts curve points and compares the output stream
module cbpg_point_checker import cbpg_pkg::*, cbpg_tb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // t_value, point_count
  input  logic                  s_tuser,   // func
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // point_x, point_y
  input  logic                  m_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data,
  input  logic                  end_check,
  output int                    mismatches,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BINOMIAL  = 3;
  localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } curve_pt_t;

  logic signed [COORD_W-1:0] ctrl_x [4];
  logic signed [COORD_W-1:0] ctrl_y [4];
  curve_pt_t expected_pts [$];
  int err_count = 0;
  int queue_depth = 0;
  bit leftovers_done = 1'b0;

  assign mismatches = err_count;
  assign pending    = queue_depth;

  // one coordinate of the curve: exact bernstein sum, round half up, saturate
  function automatic logic signed [COORD_W-1:0] bezier_axis(input logic [T_W-1:0] t,
                                                            input bit y_axis);
    logic [63:0] tt, uu;
    logic [3:0][63:0] wt;
    logic signed [127:0] acc, w_ext, c_ext;
    tt = (t > ONE_T) ? 64'(ONE_T) : 64'(t);
    uu = 64'(ONE_T) - tt;
    wt[0] = uu * uu * uu;
    wt[1] = BINOMIAL * uu * uu * tt;
    wt[2] = BINOMIAL * uu * tt * tt;
    wt[3] = tt * tt * tt;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      w_ext = {64'd0, wt[k]};
      c_ext = $signed(y_axis ? ctrl_y[k] : ctrl_x[k]);
      acc = acc + w_ext * c_ext;
    end
    acc = acc + (128'sd1 <<< (SUM_SHIFT - 1));
    acc = acc >>> SUM_SHIFT;
    if (acc > SAT_HI) return SAT_HI[COORD_W-1:0];
    else if (acc < SAT_LO) return SAT_LO[COORD_W-1:0];
    else return acc[COORD_W-1:0];
  endfunction

  function automatic void add_point(input logic [T_W-1:0] t, input logic last);
    curve_pt_t p;
    p.x = bezier_axis(t, 1'b0);
    p.y = bezier_axis(t, 1'b1);
    p.last = last;
    expected_pts = {expected_pts, p};
  endfunction

  // expand one request into the points it should produce
  function automatic void predict_request(input logic func, input logic [T_W-1:0] t_in,
                                          input logic [COUNT_W-1:0] cnt_in);
    int n;
    n = (cnt_in > MAX_POINTS) ? MAX_POINTS : int'(cnt_in);
    if (func == FUNC_AT_T) begin
      add_point(t_in, 1'b1);
    end else if (n == 1) begin
      add_point('0, 1'b1);
    end else begin
      for (int i = 0; i < n; i++)
        add_point(T_W'((i * (1 << T_FRAC_BITS)) / (n - 1)), i == n - 1);
    end
  endfunction

  function automatic void store_reg(input logic [REG_IDX_W-1:0] idx,
                                    input logic [COORD_W-1:0] val);
    case (reg_idx_t'(idx))
      REG_P0_X: ctrl_x[0] = val;
      REG_P0_Y: ctrl_y[0] = val;
      REG_P1_X: ctrl_x[1] = val;
      REG_P1_Y: ctrl_y[1] = val;
      REG_P2_X: ctrl_x[2] = val;
      REG_P2_Y: ctrl_y[2] = val;
      REG_P3_X: ctrl_x[3] = val;
      REG_P3_Y: ctrl_y[3] = val;
      default: ;
    endcase
  endfunction

  function automatic void flag_field(input string what, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    err_count++;
  endfunction

  // compare one output point against the oldest prediction
  function automatic void check_point(input logic [OUT_DATA_W-1:0] data, input logic last);
    curve_pt_t want, got;
    got.x = data[COORD_W-1:0];
    got.y = data[OUT_DATA_W-1:COORD_W];
    got.last = last;
    if (expected_pts.size() == 0) begin
      $display("%0t: point with nothing expected, expected none actual x %0d y %0d last %0b",
               $time, got.x, got.y, got.last);
      err_count++;
    end else begin
      want = expected_pts.pop_front();
      if (got.x !== want.x) flag_field("point_x", want.x, got.x);
      if (got.y !== want.y) flag_field("point_y", want.y, got.y);
      if (got.last !== want.last) flag_field("last_point", want.last, got.last);
    end
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        ctrl_x[k] = '0;
        ctrl_y[k] = '0;
      end
      expected_pts.delete();
    end else begin
      if (cfg_valid && cfg_ready) store_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready)
        predict_request(s_tuser, s_tdata[T_W-1:0], s_tdata[T_W+COUNT_W-1:T_W]);
      if (m_tvalid && m_tready) check_point(m_tdata, m_tlast);
      // predictions still waiting at the end
      if (end_check && !leftovers_done) begin
        if (expected_pts.size() != 0) begin
          $display("%0t: %0d points never arrived, oldest expected x %0d y %0d last %0b",
                   $time, expected_pts.size(), expected_pts[0].x, expected_pts[0].y,
                   expected_pts[0].last);
          err_count++;
        end
        leftovers_done = 1'b1;
      end
    end
    queue_depth <= expected_pts.size();
  end

endmodule

// File: verif/cubic_bezier_point_generator_core_tb.sv
// testbench top: clock, reset, request and register stimulus, output pacing and verdict
module cubic_bezier_point_generator_core_tb import cbpg_pkg::*, cbpg_tb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 400;
  localparam int SMALL_SPAN    = 1 << 20;
  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

  typedef enum int {
    CP_SMALL, CP_FULL, CP_MIX, CP_ALL_MAX, CP_ALL_MIN, CP_ALTERNATE
  } point_set_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // t_value, point_count
  logic                  s_tuser = 1'b0; // func
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // point_x, point_y
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [COORD_W-1:0]    cfg_data = '0;
  logic                  end_check = 1'b0;
  int                    mismatches;
  int                    pending;

  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int hold_reqs = 0;
  int hold_seen = 0;
  int stall_left = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  cubic_bezier_point_generator_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cbpg_point_checker point_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .end_check(end_check), .mismatches(mismatches), .pending(pending)
  );

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // output side pacing: long hold on request, else random stall bursts
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen  <= hold_reqs;
      m_tready   <= 1'b0;
      stall_left <= LONG_HOLD - 1;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [COORD_W-1:0] pick_coord(input point_set_t kind, input int r);
    logic [COORD_W-1:0] v;
    int sel;
    sel = (kind == CP_MIX) ? $urandom_range(0, 4) : 0;
    case (kind)
      CP_SMALL:     v = $urandom_range(0, 2 * SMALL_SPAN) - SMALL_SPAN;
      CP_FULL:      v = $urandom;
      CP_ALL_MAX:   v = COORD_MAX;
      CP_ALL_MIN:   v = COORD_MIN;
      CP_ALTERNATE: v = ((r / 2) % 2 == 0) ? COORD_MIN : COORD_MAX;
      default: begin
        // per register mix of bounds, zero and random values
        if (sel == 0) v = COORD_MIN;
        else if (sel == 1) v = COORD_MAX;
        else if (sel == 2) v = '0;
        else if (sel == 3) v = $urandom;
        else v = $urandom_range(0, 2 * SMALL_SPAN) - SMALL_SPAN;
      end
    endcase
    return v;
  endfunction

  // stop offering, wait for every predicted point, then let the core settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // rewrite all control points while the core is idle
  task automatic load_points(input point_set_t kind);
    wait_idle();
    for (int r = 0; r <= int'(REG_P3_Y); r++) write_reg(reg_idx_t'(r), pick_coord(kind, r));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input logic func, input logic [T_W-1:0] t_val,
                              input logic [COUNT_W-1:0] cnt);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {cnt, t_val};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // mostly single points and short runs, a few full and clamped runs, some empty ones
  task automatic send_random_request();
    int pick;
    logic [T_W-1:0] t_val;
    logic [COUNT_W-1:0] cnt;
    pick  = $urandom_range(0, 19);
    t_val = ($urandom_range(0, 3) == 0) ? T_W'($urandom) : T_W'($urandom_range(0, ONE_T));
    cnt   = COUNT_W'($urandom);
    if (pick < 9) send_request(FUNC_AT_T, t_val, cnt);
    else if (pick < 17) send_request(FUNC_SPREAD, t_val, COUNT_W'($urandom_range(1, 8)));
    else if (pick < 18) send_request(FUNC_SPREAD, t_val, COUNT_W'($urandom_range(9, 64)));
    else if (pick < 19) send_request(FUNC_SPREAD, t_val, COUNT_W'($urandom_range(65, 127)));
    else send_request(FUNC_SPREAD, t_val, '0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: t at the ends, middle, beyond one; every count corner
    load_points(CP_SMALL);
    send_request(FUNC_AT_T, 17'd0, '0);
    send_request(FUNC_AT_T, 17'd65536, '0);
    send_request(FUNC_AT_T, 17'd32768, '0);
    send_request(FUNC_AT_T, 17'd1, '0);
    send_request(FUNC_AT_T, 17'd65535, '0);
    send_request(FUNC_AT_T, 17'd65537, '0);
    send_request(FUNC_AT_T, 17'd131071, '0);
    send_request(FUNC_SPREAD, '0, 7'd0);
    send_request(FUNC_SPREAD, '0, 7'd1);
    send_request(FUNC_SPREAD, '0, 7'd2);
    send_request(FUNC_SPREAD, '0, 7'd3);
    send_request(FUNC_SPREAD, '0, 7'd64);
    send_request(FUNC_SPREAD, '0, 7'd65);
    send_request(FUNC_SPREAD, '0, 7'd127);

    // directed: control points at the coordinate bounds
    load_points(CP_ALL_MAX);
    send_request(FUNC_AT_T, 17'd21845, '0);
    send_request(FUNC_SPREAD, '0, 7'd5);
    load_points(CP_ALL_MIN);
    send_request(FUNC_AT_T, 17'd43690, '0);
    send_request(FUNC_SPREAD, '0, 7'd4);
    load_points(CP_ALTERNATE);
    send_request(FUNC_AT_T, 17'd32768, '0);
    send_request(FUNC_SPREAD, '0, 7'd7);
    send_request(FUNC_AT_T, 17'd65536, '0);

    // random, full range control points
    load_points(CP_FULL);
    repeat (20) send_random_request();

    // output held off for a long stretch while requests keep coming
    load_points(CP_MIX);
    tx_gaps = 1'b0;
    hold_reqs <= hold_reqs + 1;
    repeat (10) send_request(FUNC_AT_T, T_W'($urandom_range(0, ONE_T)), COUNT_W'($urandom));
    tx_gaps = 1'b1;
    repeat (20) send_random_request();

    // steady output, with a full pause of the requests halfway
    load_points(CP_SMALL);
    rx_gaps <= 1'b0;
    repeat (15) send_random_request();
    wait_idle();
    repeat (15) send_random_request();

    // closing stretch with no idling on either side
    load_points(CP_MIX);
    tx_gaps = 1'b0;
    repeat (20) send_random_request();

    wait_idle();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
